/* hdl/ntsd_pkg.sv */
// ----------------------------------------------------------------------------
// ntsd_pkg
// Shared constants, types and helper functions for the segment digit decoder.
// ----------------------------------------------------------------------------
package ntsd_pkg;

  localparam int unsigned VALUE_W = 18;
  localparam int unsigned REM_W   = 17;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEG_W   = 8;

  localparam logic [VALUE_W-1:0] OVER_LIMIT = 18'd200000;
  localparam logic [VALUE_W-1:0] ONE_BAND   = 18'd100000;
  localparam logic [SEG_W-1:0]   LEADING_ONE = 8'h08;

  localparam logic [REM_W-1:0] UNIT_10000 = 17'd10000;
  localparam logic [REM_W-1:0] UNIT_1000  = 17'd1000;
  localparam logic [REM_W-1:0] UNIT_100   = 17'd100;
  localparam logic [REM_W-1:0] UNIT_10    = 17'd10;

  typedef struct packed {
    logic [DIGIT_W-1:0] q;
    logic [REM_W-1:0]   rem;
  } digit_split_t;

  typedef struct packed {
    logic band;
    logic over;
  } disp_flags_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hf5;
      4'd1: s = 8'h60;
      4'd2: s = 8'hd3;
      4'd3: s = 8'hf2;
      4'd4: s = 8'h66;
      4'd5: s = 8'hb6;
      4'd6: s = 8'hb7;
      4'd7: s = 8'he0;
      4'd8: s = 8'hf7;
      4'd9: s = 8'hf6;
      default: s = '0;
    endcase
    return s;
  endfunction

  // x must be below 10*unit; unit is a constant at every call site
  function automatic digit_split_t dec_split(input logic [REM_W-1:0] x,
                                             input logic [REM_W-1:0] unit);
    digit_split_t r;
    r.q   = '0;
    r.rem = x;
    for (int k = 1; k < 10; k++) begin
      if (x >= REM_W'(k) * unit) begin
        r.q   = DIGIT_W'(k);
        r.rem = x - REM_W'(k) * unit;
      end
    end
    return r;
  endfunction

endpackage

/* hdl/ntsd_seg_encode.sv */
// ----------------------------------------------------------------------------
// ntsd_seg_encode
// Leading-zero blanking, range blanking, leading-one mark and segment pattern lookup.
// ----------------------------------------------------------------------------
module ntsd_seg_encode (
  input  logic [ntsd_pkg::DIGIT_W-1:0] d4,
  input  logic [ntsd_pkg::DIGIT_W-1:0] d3,
  input  logic [ntsd_pkg::DIGIT_W-1:0] d2,
  input  logic [ntsd_pkg::DIGIT_W-1:0] d1,
  input  logic [ntsd_pkg::DIGIT_W-1:0] d0,
  input  ntsd_pkg::disp_flags_t        flags,
  output logic [ntsd_pkg::SEG_W-1:0]   c4,
  output logic [ntsd_pkg::SEG_W-1:0]   c3,
  output logic [ntsd_pkg::SEG_W-1:0]   c2,
  output logic [ntsd_pkg::SEG_W-1:0]   c1,
  output logic [ntsd_pkg::SEG_W-1:0]   c0
);

  logic lit4, lit3, lit2, lit1;

  always_comb begin
    lit4 = flags.band | (d4 != '0);
    lit3 = lit4 | (d3 != '0);
    lit2 = lit3 | (d2 != '0);
    lit1 = lit2 | (d1 != '0);
    c4 = '0;
    c3 = '0;
    c2 = '0;
    c1 = '0;
    c0 = '0;
    if (!flags.over) begin
      if (lit4) c4 = ntsd_pkg::seg_of(d4);
      if (lit3) c3 = ntsd_pkg::seg_of(d3);
      if (lit2) c2 = ntsd_pkg::seg_of(d2);
      if (lit1) c1 = ntsd_pkg::seg_of(d1);
      c0 = ntsd_pkg::seg_of(d0);
      if (flags.band) c0 = c0 | ntsd_pkg::LEADING_ONE;
    end
  end

endmodule

/* hdl/number_to_segment_digits.sv */
// ----------------------------------------------------------------------------
// number_to_segment_digits
// Binary value to five seven-segment bytes, with range flag and leading one.
// ----------------------------------------------------------------------------
// Structure: six register stages; a value passes from v1 through v5 to out_valid,
// with every register loading only while advance is high.
// Throughput: one value per cycle; six register stages (range split, four
// decimal digit stages, segment encode) share one stall enable.
// Reset: rst clears all stage valid bits; data registers are not reset.
module number_to_segment_digits (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ntsd_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntsd_pkg::SEG_W-1:0]    digit4_code,
  output logic [ntsd_pkg::SEG_W-1:0]    digit3_code,
  output logic [ntsd_pkg::SEG_W-1:0]    digit2_code,
  output logic [ntsd_pkg::SEG_W-1:0]    digit1_code,
  output logic [ntsd_pkg::SEG_W-1:0]    digit0_code,
  output logic                          over_range
);

  logic advance;

  logic v1, v2, v3, v4, v5;
  ntsd_pkg::disp_flags_t f1, f2, f3, f4, f5;
  logic [ntsd_pkg::REM_W-1:0]   r1;
  logic [13:0]                  r2;
  logic [9:0]                   r3;
  logic [6:0]                   r4;
  logic [ntsd_pkg::DIGIT_W-1:0] d4_2, d4_3, d4_4, d4_5;
  logic [ntsd_pkg::DIGIT_W-1:0] d3_3, d3_4, d3_5;
  logic [ntsd_pkg::DIGIT_W-1:0] d2_4, d2_5;
  logic [ntsd_pkg::DIGIT_W-1:0] d1_5, d0_5;

  ntsd_pkg::disp_flags_t        f_in;
  logic [ntsd_pkg::VALUE_W-1:0] r_in;
  ntsd_pkg::digit_split_t       sp2, sp3, sp4, sp5;
  logic [ntsd_pkg::SEG_W-1:0]   c4, c3, c2, c1, c0;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_comb begin
    f_in.over = (value >= ntsd_pkg::OVER_LIMIT);
    f_in.band = !f_in.over && (value >= ntsd_pkg::ONE_BAND);
    r_in      = f_in.band ? (value - ntsd_pkg::ONE_BAND) : value;
    sp2 = ntsd_pkg::dec_split(r1, ntsd_pkg::UNIT_10000);
    sp3 = ntsd_pkg::dec_split(ntsd_pkg::REM_W'(r2), ntsd_pkg::UNIT_1000);
    sp4 = ntsd_pkg::dec_split(ntsd_pkg::REM_W'(r3), ntsd_pkg::UNIT_100);
    sp5 = ntsd_pkg::dec_split(ntsd_pkg::REM_W'(r4), ntsd_pkg::UNIT_10);
  end

  ntsd_seg_encode u_encode (
    .d4    (d4_5),
    .d3    (d3_5),
    .d2    (d2_5),
    .d1    (d1_5),
    .d0    (d0_5),
    .flags (f5),
    .c4    (c4),
    .c3    (c3),
    .c2    (c2),
    .c1    (c1),
    .c0    (c0)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1 <= f_in;
      r1 <= ntsd_pkg::REM_W'(r_in);

      f2   <= f1;
      d4_2 <= sp2.q;
      r2   <= sp2.rem[13:0];

      f3   <= f2;
      d4_3 <= d4_2;
      d3_3 <= sp3.q;
      r3   <= sp3.rem[9:0];

      f4   <= f3;
      d4_4 <= d4_3;
      d3_4 <= d3_3;
      d2_4 <= sp4.q;
      r4   <= sp4.rem[6:0];

      f5   <= f4;
      d4_5 <= d4_4;
      d3_5 <= d3_4;
      d2_5 <= d2_4;
      d1_5 <= sp5.q;
      d0_5 <= sp5.rem[ntsd_pkg::DIGIT_W-1:0];

      digit4_code <= c4;
      digit3_code <= c3;
      digit2_code <= c2;
      digit1_code <= c1;
      digit0_code <= c0;
      over_range  <= f5.over;
    end
  end

endmodule
